>>> hdl/assert_macros.svh
// assertion macros for the ghash engine
// used by the top level; expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GHE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghash engine check failed");

// next-cycle implication
`define GHE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghash engine check failed");

`endif

>>> hdl/ghe_pkg.sv
// shared types and constants of the ghash engine
// no dependencies
`timescale 1ns / 1ps

package ghe_pkg;

  // input command codes
  localparam logic [1:0] CMD_AAD  = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_FIN  = 2'd2;

  // configuration register indexes
  localparam logic CFG_KEY_HI = 1'b0;
  localparam logic CFG_KEY_LO = 1'b1;

  // gcm reduction constant in reflected bit order
  localparam logic [127:0] GF_R = {8'hE1, 120'd0};

  // multiplier steps per cycle and cycles per block
  localparam int MUL_BITS   = 8;
  localparam int MUL_CYCLES = 128 / MUL_BITS;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture the input beat
    logic mul_pend;   // hash the padded pending block
    logic append;     // append chunk bytes, hash if block fills
    logic mul_len;    // hash the length block
    logic load_out;   // write the result register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       phase;
    logic       fill_nz;
    logic       app_full;
    logic       mul_done;
  } ctl_stat_t;

endpackage

>>> hdl/ghe_gfmul.sv
// gf(2^128) multiplier, eight bits of the operand per cycle
// depends on ghe_pkg
`timescale 1ns / 1ps

module ghe_gfmul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] x_in,
  input  logic [127:0] h_in,
  output logic         done,
  output logic [127:0] z
);

  logic [127:0] z_r, v_r, x_r;
  logic [127:0] z_nxt, v_nxt, x_nxt;
  logic [3:0]   cnt_r;
  logic         busy_r, done_r;
  logic         lsb;

  // eight shift-and-add steps, msb of the operand first
  always_comb begin
    z_nxt = z_r;
    v_nxt = v_r;
    x_nxt = x_r;
    lsb   = 1'b0;
    for (int i = 0; i < ghe_pkg::MUL_BITS; i++) begin
      if (x_nxt[127]) z_nxt = z_nxt ^ v_nxt;
      lsb   = v_nxt[0];
      v_nxt = v_nxt >> 1;
      if (lsb) v_nxt = v_nxt ^ ghe_pkg::GF_R;
      x_nxt = x_nxt << 1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(ghe_pkg::MUL_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      z_r <= '0;
      v_r <= h_in;
      x_r <= x_in;
    end else if (busy_r) begin
      z_r <= z_nxt;
      v_r <= v_nxt;
      x_r <= x_nxt;
    end
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

>>> hdl/ghe_datapath.sv
// ghash datapath: key, accumulator, byte buffer, totals, result register
// depends on ghe_pkg and ghe_gfmul
`timescale 1ns / 1ps

module ghe_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [63:0]         cfg_wdata,
  input  logic [135:0]        in_tdata,
  input  logic [1:0]          in_tuser,
  input  ghe_pkg::ctl_cmd_t   cmd,
  output ghe_pkg::ctl_stat_t  stat,
  output logic [127:0]        out_tdata,
  output logic [1:0]          out_tuser
);

  logic [127:0] key_r, acc_r, pend_r, chunk_r;
  logic [3:0]   fill_r;
  logic [4:0]   cnt_r;
  logic [1:0]   cmd_r;
  logic [63:0]  aad_tot_r, dat_tot_r;
  logic         phase_r;
  logic [127:0] res_tag_r;
  logic [1:0]   res_flag_r;

  logic [127:0] chunk_m, mul_x, mul_z;
  logic [255:0] wide;
  logic [4:0]   sum;
  logic [4:0]   cnt_in;
  logic         mul_start, mul_done, is_fin;

  // clamp the byte count to sixteen
  assign cnt_in = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];

  // merge chunk bytes behind the pending bytes
  assign chunk_m = chunk_r & ~({128{1'b1}} >> {cnt_r, 3'b000});
  assign wide    = {pend_r, 128'd0} | ({chunk_m, 128'd0} >> {fill_r, 3'b000});
  assign sum     = {1'b0, fill_r} + cnt_r;

  // multiplier operand
  always_comb begin
    priority if (cmd.mul_pend) mul_x = acc_r ^ pend_r;
    else if (cmd.mul_len)      mul_x = acc_r ^ {aad_tot_r << 3, dat_tot_r << 3};
    else                       mul_x = acc_r ^ wide[255:128];
  end
  assign mul_start = cmd.mul_pend | cmd.mul_len | (cmd.append & sum[4]);

  ghe_gfmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x_in  (mul_x),
    .h_in  (key_r),
    .done  (mul_done),
    .z     (mul_z)
  );

  assign is_fin = (cmd_r == ghe_pkg::CMD_FIN);

  // hash subkey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ghe_pkg::CFG_KEY_HI: key_r[127:64] <= cfg_wdata;
        ghe_pkg::CFG_KEY_LO: key_r[63:0]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // message context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pend_r    <= '0;
      fill_r    <= '0;
      aad_tot_r <= '0;
      dat_tot_r <= '0;
      phase_r   <= 1'b0;
    end else begin
      if (mul_done) acc_r <= mul_z;
      if (cmd.mul_pend) begin
        pend_r <= '0;
        fill_r <= '0;
      end
      if (cmd.append) begin
        fill_r <= sum[3:0];
        pend_r <= sum[4] ? wide[127:0] : wide[255:128];
        if (cmd_r == ghe_pkg::CMD_DATA) begin
          phase_r   <= 1'b1;
          dat_tot_r <= dat_tot_r + 64'(cnt_r);
        end else begin
          aad_tot_r <= aad_tot_r + 64'(cnt_r);
        end
      end
      if (cmd.load_out && is_fin) begin
        acc_r     <= '0;
        pend_r    <= '0;
        fill_r    <= '0;
        aad_tot_r <= '0;
        dat_tot_r <= '0;
        phase_r   <= 1'b0;
      end
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r   <= in_tuser;
      chunk_r <= {in_tdata[63:0], in_tdata[127:64]};
      cnt_r   <= cnt_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_tag_r  <= is_fin ? acc_r : 128'd0;
      res_flag_r <= {(cmd_r == ghe_pkg::CMD_AAD) && phase_r, is_fin};
    end
  end

  assign out_tdata = {res_tag_r[63:0], res_tag_r[127:64]};
  assign out_tuser = res_flag_r;

  assign stat.cmd      = cmd_r;
  assign stat.phase    = phase_r;
  assign stat.fill_nz  = (fill_r != 4'd0);
  assign stat.app_full = sum[4];
  assign stat.mul_done = mul_done;

endmodule

>>> hdl/ghe_ctrl.sv
// ghash controller: sequences padding, appending, hashing and result
// depends on ghe_pkg
`timescale 1ns / 1ps

module ghe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  ghe_pkg::ctl_stat_t  stat,
  output ghe_pkg::ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_APP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt, ret_r, ret_nxt;
  logic       oval_r, oval_nxt;
  logic       slot_free;

  assign slot_free = !oval_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_PAD;
        end
      end
      S_PAD: begin
        if (stat.fill_nz && (stat.cmd == ghe_pkg::CMD_FIN ||
            (stat.cmd == ghe_pkg::CMD_DATA && !stat.phase))) begin
          cmd.mul_pend = 1'b1;
          ret_nxt      = S_APP;
          state_nxt    = S_MUL;
        end else begin
          state_nxt = S_APP;
        end
      end
      S_APP: begin
        state_nxt = S_OUT;
        unique case (stat.cmd)
          ghe_pkg::CMD_AAD, ghe_pkg::CMD_DATA: begin
            if (!(stat.cmd == ghe_pkg::CMD_AAD && stat.phase)) begin
              cmd.append = 1'b1;
              if (stat.app_full) begin
                ret_nxt   = S_OUT;
                state_nxt = S_MUL;
              end
            end
          end
          ghe_pkg::CMD_FIN: begin
            cmd.mul_len = 1'b1;
            ret_nxt     = S_OUT;
            state_nxt   = S_MUL;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        if (stat.mul_done) state_nxt = ret_r;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    oval_nxt = oval_r;
    if (out_tready) oval_nxt = 1'b0;
    if (cmd.load_out) oval_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;

endmodule

>>> hdl/ghash_incremental_engine.sv
// Incremental GCM GHASH engine. Each input beat passes the idle, pad, append
// and output states, plus a multiplier pass for every 16-byte block hashed
// (at most two per beat: a padded tail and a full block, or a padded tail and
// the length block on finish); the GF(2^128) multiplier consumes eight bits
// of the hashed block per cycle and is the only hash unit.
// A new beat is taken while the previous result still waits on the output.
// Top level: joins the controller and the datapath; depends on ghe_pkg,
// ghe_ctrl, ghe_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghash_incremental_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // chunk_high, chunk_low, byte_count, zero fill
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // tag_high, tag_low
  output logic [1:0]   out_tuser   // tag_valid, status
);

  ghe_pkg::ctl_cmd_t  cmd;
  ghe_pkg::ctl_stat_t stat;

  ghe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ghe_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // a result is never written over one still waiting
  `GHE_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready)
  // one beat at a time
  `GHE_ASSERT_NXT(a_one_beat, in_tvalid && in_tready, !in_tready)
  // only one hash operation starts at a time
  `GHE_ASSERT_NOW(a_one_op, 1'b1, $onehot0({cmd.mul_pend, cmd.append, cmd.mul_len, cmd.load_out}))
  // multiplier finishes only while the controller waits on it
  `GHE_ASSERT_NOW(a_done_idle, stat.mul_done, !in_tready)

endmodule

>>> verif/ghash_incremental_engine_checker.sv
// result checker for the ghash engine: tracks key writes and input beats,
// predicts each result in gf(2^128) and compares it with the output beats
// depends on ghe_pkg for the command and register codes
`timescale 1ns / 1ps

module ghash_incremental_engine_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           tags_waiting
);

  typedef struct packed {
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        tag_ok;
    logic        rejected;
  } tag_beat_t;

  tag_beat_t     tag_queue[$];
  logic [127:0]  key_h;
  logic [127:0]  acc;
  logic [127:0]  pend;
  logic [4:0]    pend_fill;
  logic [63:0]   aad_total;
  logic [63:0]   data_total;
  logic          data_phase;

  // gf(2^128) product of two blocks, reflected gcm bit order
  function automatic logic [127:0] gf_mult(logic [127:0] x, logic [127:0] y);
    logic [127:0] z;
    logic [127:0] v;
    logic         lsb;
    z = '0;
    v = y;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v ^= {8'hE1, 120'd0};
    end
    return z;
  endfunction

  task automatic hash_pending();
    acc = gf_mult(acc ^ pend, key_h);
    pend = '0;
    pend_fill = 5'd0;
  endtask

  task automatic pad_tail();
    if (pend_fill != 0) hash_pending();
  endtask

  task automatic append_chunk(logic [127:0] chunk, int n);
    for (int i = 0; i < n; i++) begin
      pend[127 - 8*pend_fill -: 8] = chunk[127 - 8*i -: 8];
      pend_fill = pend_fill + 5'd1;
      if (pend_fill == 16) hash_pending();
    end
  endtask

  task automatic clear_msg();
    acc = '0;
    pend = '0;
    pend_fill = 5'd0;
    aad_total = '0;
    data_total = '0;
    data_phase = 1'b0;
  endtask

  // predict the result of one accepted input beat
  task automatic predict_tag(logic [1:0] cmd, logic [127:0] chunk, logic [4:0] cnt_raw);
    tag_beat_t t;
    int        n;
    t = '0;
    n = (cnt_raw > 16) ? 16 : int'(cnt_raw);
    case (cmd)
      ghe_pkg::CMD_AAD: begin
        if (data_phase) t.rejected = 1'b1;
        else begin
          aad_total += 64'(n);
          append_chunk(chunk, n);
        end
      end
      ghe_pkg::CMD_DATA: begin
        if (!data_phase) begin
          pad_tail();
          data_phase = 1'b1;
        end
        data_total += 64'(n);
        append_chunk(chunk, n);
      end
      ghe_pkg::CMD_FIN: begin
        pad_tail();
        pend = {aad_total << 3, data_total << 3};
        hash_pending();
        t.tag_hi = acc[127:64];
        t.tag_lo = acc[63:0];
        t.tag_ok = 1'b1;
        clear_msg();
      end
      default: ;
    endcase
    tag_queue.push_back(t);
  endtask

  // watch the three ports at each rising edge
  always @(posedge clk) begin
    tag_beat_t want;
    tag_beat_t got;
    if (!rst_n) begin
      key_h = '0;
      clear_msg();
      tag_queue.delete();
      fail_count <= 0;
      tags_waiting <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == ghe_pkg::CFG_KEY_HI) key_h[127:64] = cfg_wdata;
        else key_h[63:0] = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tuser[0], out_tuser[1]};
        if (tag_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = tag_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch: expected hi %h lo %h valid %b status %b, ",
                        "got hi %h lo %h valid %b status %b"},
                       want.tag_hi, want.tag_lo, want.tag_ok, want.rejected,
                       got.tag_hi, got.tag_lo, got.tag_ok, got.rejected);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_tag(in_tuser, {in_tdata[63:0], in_tdata[127:64]}, in_tdata[132:128]);
      tags_waiting <= tag_queue.size();
    end
  end

endmodule

>>> verif/tb_ghash_incremental_engine.sv
// top of the ghash engine testbench: clock, reset, key writes and input beats
// depends on ghe_pkg, ghash_incremental_engine and its checker
`timescale 1ns / 1ps

module tb_ghash_incremental_engine;

  localparam int CYCLE_LIMIT = 1000000;
  // command code the engine ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           tags_waiting;
  int           cycles = 0;
  int           burst_left = 0;
  int           stall_mode = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ghash_incremental_engine dut (.*);

  ghash_incremental_engine_checker chk (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern: phases of always ready, random and mostly stalled
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_beat(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                           logic [4:0] cnt);
    logic rdy;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'd0, cnt, lo, hi};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    // bursts with random gaps between them
    if (burst_left > 0) burst_left--;
    else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = int'($urandom_range(0, 10));
    end
  endtask

  task automatic send_rand(logic [1:0] cmd, logic [4:0] cnt);
    send_beat(cmd, {$urandom, $urandom}, {$urandom, $urandom}, cnt);
  endtask

  // key change only once every tag is back and the engine has settled
  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tags_waiting != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= ghe_pkg::CFG_KEY_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr <= ghe_pkg::CFG_KEY_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [4:0] rand_count();
    int r;
    r = int'($urandom_range(0, 19));
    if (r == 0) return 5'd0;
    if (r == 1) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(1, 16));
  endfunction

  initial begin
    int items;
    int n_aad;
    int n_data;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, extremes of counts and chunks
    send_rand(ghe_pkg::CMD_FIN, 5'd0);
    load_key('1, '1);
    send_beat(ghe_pkg::CMD_AAD, '1, '1, 5'd16);
    send_beat(ghe_pkg::CMD_AAD, '0, '0, 5'd1);
    send_beat(ghe_pkg::CMD_AAD, '1, '1, 5'd0);
    send_beat(ghe_pkg::CMD_DATA, '1, '0, 5'd15);
    send_beat(ghe_pkg::CMD_AAD, '1, '1, 5'd4);
    send_beat(ghe_pkg::CMD_DATA, '0, '1, 5'd31);
    send_beat(ghe_pkg::CMD_DATA, '1, '1, 5'd17);
    send_rand(CMD_UNUSED, 5'd8);
    send_beat(ghe_pkg::CMD_FIN, '1, '1, 5'd31);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_beat(ghe_pkg::CMD_DATA, '1, '1, 5'd0);
    send_rand(ghe_pkg::CMD_DATA, 5'd7);
    send_rand(ghe_pkg::CMD_FIN, 5'd16);
    send_rand(ghe_pkg::CMD_AAD, 5'd9);
    send_rand(ghe_pkg::CMD_FIN, 5'd0);
    send_rand(ghe_pkg::CMD_DATA, 5'd16);
    send_rand(ghe_pkg::CMD_DATA, 5'd16);
    send_rand(ghe_pkg::CMD_FIN, 5'd1);
    load_key('0, '0);
    send_rand(ghe_pkg::CMD_AAD, 5'd5);
    send_rand(ghe_pkg::CMD_DATA, 5'd3);
    send_rand(ghe_pkg::CMD_FIN, 5'd3);

    // random messages, with a new key every few of them
    items = 0;
    while (items < 1550) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: load_key('1, '1);
          1: load_key('0, {$urandom, $urandom});
          default: load_key({$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
      n_aad = int'($urandom_range(0, 5));
      n_data = int'($urandom_range(0, 8));
      for (int i = 0; i < n_aad; i++) begin
        send_rand(ghe_pkg::CMD_AAD, rand_count());
        items++;
      end
      for (int i = 0; i < n_data; i++) begin
        // broken sequences: aad after data or the unused command
        case ($urandom_range(0, 15))
          0: send_rand(ghe_pkg::CMD_AAD, rand_count());
          1: send_rand(CMD_UNUSED, rand_count());
          default: send_rand(ghe_pkg::CMD_DATA, rand_count());
        endcase
        items++;
      end
      send_rand(ghe_pkg::CMD_FIN, 5'($urandom));
      items++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tags_waiting != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && tags_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
